@@ rtl/apsp_pkg.sv @@
package apsp_pkg;

    // vertices in use at most, and weight bits taken from an edge load
    localparam int NODES     = 64;
    localparam int COST_BITS = 16;

    // node fields are 6 bits wide, so the matrix always has 64 x 64 slots
    localparam int NODE_W     = 6;
    localparam int CNT_W      = NODE_W + 1;
    localparam int NODE_SLOTS = 1 << NODE_W;
    localparam int ADDR_W     = 2 * NODE_W;
    localparam int MAT_DEPTH  = NODE_SLOTS * NODE_SLOTS;
    localparam int CLR_W      = ADDR_W + 1;

    localparam int DIST_W   = 24;
    localparam int HOP_W    = 7;
    localparam int ENTRY_W  = HOP_W + DIST_W;
    localparam int EDGE_W   = 16;

    localparam logic [DIST_W-1:0] DIST_INF  = 24'hFFFFFF;
    localparam logic [DIST_W-1:0] DIST_MAX  = 24'hFFFFFE;
    localparam logic [HOP_W-1:0]  HOP_EMPTY = 7'd64;
    localparam logic [CNT_W-1:0]  MAX_PATH  = 7'd64;
    localparam logic [CNT_W-1:0]  NODES_CNT = CNT_W'(NODES);
    localparam logic [CNT_W-1:0]  NODE_COUNT_RESET = 7'd64;
    localparam logic [CLR_W-1:0]  CLR_LAST  = CLR_W'(MAT_DEPTH - 1);

    localparam logic [EDGE_W-1:0] COST_MASK =
        (COST_BITS >= EDGE_W) ? {EDGE_W{1'b1}} : EDGE_W'((64'd1 << COST_BITS) - 64'd1);

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_LOAD    = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_C_IK,
        ST_C_IKW,
        ST_C_KJ,
        ST_C_IJ,
        ST_C_UPD,
        ST_Q_START,
        ST_Q_DIST,
        ST_Q1_RD,
        ST_Q1_CHK,
        ST_Q_ONE,
        ST_Q2_EMIT,
        ST_Q2_RD,
        ST_Q2_NXT
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [DIST_W-1:0] cost;
        logic              no_path;
        logic              last;
    } result_t;

endpackage

@@ rtl/apsp_ram.sv @@
module apsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/apsp_ctrl.sv @@
module apsp_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [apsp_pkg::CNT_W-1:0]    node_count,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    operation,
    input  logic [apsp_pkg::NODE_W-1:0]   source_node,
    input  logic [apsp_pkg::NODE_W-1:0]   dest_node,
    input  logic [apsp_pkg::EDGE_W-1:0]   edge_cost,
    input  logic                          slot_free,
    output logic                          emit_valid,
    output apsp_pkg::result_t             emit
);

    import apsp_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    ncount_reg, ncount_next;
    logic [NODE_W-1:0]   s_reg, s_next, d_reg, d_next, cur_reg, cur_next;
    logic [CNT_W-1:0]    k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CLR_W-1:0]    clr_reg, clr_next;
    logic [DIST_W-1:0]   ik_reg, ik_next, kj_reg, kj_next, cost_reg, cost_next;
    logic [DIST_W-1:0]   one_cost_reg, one_cost_next;
    logic                one_np_reg, one_np_next;
    logic [HOP_W-1:0]    hopik_reg, hopik_next;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0]  mem_wdata, mem_rdata;
    logic [DIST_W-1:0]   rd_dist;
    logic [HOP_W-1:0]    rd_hop;
    logic [CNT_W-1:0]    n_act;
    logic [DIST_W:0]     sum;
    logic [DIST_W-1:0]   sum_sat;
    logic                row_last, k_last;

    // distance in the low bits, next hop above it
    apsp_ram #(.WIDTH(ENTRY_W), .DEPTH(MAT_DEPTH)) u_mat (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_dist   = mem_rdata[DIST_W-1:0];
    assign rd_hop    = mem_rdata[ENTRY_W-1:DIST_W];
    assign n_act     = (ncount_reg > NODES_CNT) ? NODES_CNT : ncount_reg;
    assign sum       = {1'b0, ik_reg} + {1'b0, kj_reg};
    assign sum_sat   = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
    assign row_last  = (i_reg + 1'b1) == n_act;
    assign k_last    = (k_reg + 1'b1) == n_act;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            ncount_reg <= NODE_COUNT_RESET;
            clr_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ncount_reg <= ncount_next;
            clr_reg    <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        d_reg        <= d_next;
        cur_reg      <= cur_next;
        k_reg        <= k_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        cnt_reg      <= cnt_next;
        ik_reg       <= ik_next;
        kj_reg       <= kj_next;
        cost_reg     <= cost_next;
        one_cost_reg <= one_cost_next;
        one_np_reg   <= one_np_next;
        hopik_reg    <= hopik_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        ncount_next   = ncount_reg;
        s_next        = s_reg;
        d_next        = d_reg;
        cur_next      = cur_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        cnt_next      = cnt_reg;
        clr_next      = clr_reg;
        ik_next       = ik_reg;
        kj_next       = kj_reg;
        cost_next     = cost_reg;
        one_cost_next = one_cost_reg;
        one_np_next   = one_np_reg;
        hopik_next    = hopik_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_raddr     = '0;
        in_ready      = 1'b0;
        emit_valid    = 1'b0;
        emit          = '0;

        if (cfg_valid)
        begin
            ncount_next = node_count;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg[ADDR_W-1:0];
                mem_wdata = {HOP_EMPTY,
                             (clr_reg[ADDR_W-1:NODE_W] == clr_reg[NODE_W-1:0]) ?
                             DIST_W'(0) : DIST_INF};
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    s_next = source_node;
                    d_next = dest_node;
                    case (op_t'(operation))
                        OP_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        OP_LOAD:
                        begin
                            if (source_node != dest_node &&
                                {1'b0, source_node} < NODES_CNT &&
                                {1'b0, dest_node} < NODES_CNT)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = {source_node, dest_node};
                                mem_wdata = {{1'b0, dest_node},
                                             DIST_W'(edge_cost & COST_MASK)};
                            end
                        end
                        OP_COMPUTE:
                        begin
                            k_next = '0;
                            i_next = '0;
                            if (n_act != '0)
                            begin
                                state_next = ST_C_IK;
                            end
                        end
                        OP_QUERY:
                        begin
                            state_next = ST_Q_START;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_C_IK:
            begin
                mem_raddr  = {i_reg[NODE_W-1:0], k_reg[NODE_W-1:0]};
                state_next = ST_C_IKW;
            end
            ST_C_IKW:
            begin
                ik_next    = rd_dist;
                hopik_next = rd_hop;
                if (rd_dist == DIST_INF)
                begin
                    // infinite leg: skip the whole row
                    state_next = ST_C_IK;
                    i_next     = i_reg + 1'b1;
                    if (row_last)
                    begin
                        i_next = '0;
                        k_next = k_reg + 1'b1;
                        if (k_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    j_next     = '0;
                    state_next = ST_C_KJ;
                end
            end
            ST_C_KJ:
            begin
                mem_raddr  = {k_reg[NODE_W-1:0], j_reg[NODE_W-1:0]};
                state_next = ST_C_IJ;
            end
            ST_C_IJ:
            begin
                kj_next    = rd_dist;
                mem_raddr  = {i_reg[NODE_W-1:0], j_reg[NODE_W-1:0]};
                state_next = ST_C_UPD;
            end
            ST_C_UPD:
            begin
                if (kj_reg != DIST_INF && rd_dist > sum_sat)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {i_reg[NODE_W-1:0], j_reg[NODE_W-1:0]};
                    mem_wdata = {hopik_reg, sum_sat};
                end
                j_next     = j_reg + 1'b1;
                state_next = ST_C_KJ;
                if ((j_reg + 1'b1) == n_act)
                begin
                    state_next = ST_C_IK;
                    i_next     = i_reg + 1'b1;
                    if (row_last)
                    begin
                        i_next = '0;
                        k_next = k_reg + 1'b1;
                        if (k_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_Q_START:
            begin
                if ({1'b0, s_reg} >= n_act || {1'b0, d_reg} >= n_act)
                begin
                    one_cost_next = DIST_INF;
                    one_np_next   = 1'b1;
                    state_next    = ST_Q_ONE;
                end
                else if (s_reg == d_reg)
                begin
                    one_cost_next = '0;
                    one_np_next   = 1'b0;
                    state_next    = ST_Q_ONE;
                end
                else
                begin
                    mem_raddr  = {s_reg, d_reg};
                    state_next = ST_Q_DIST;
                end
            end
            ST_Q_DIST:
            begin
                cost_next  = rd_dist;
                cnt_next   = CNT_W'(1);
                cur_next   = s_reg;
                state_next = ST_Q1_RD;
            end
            ST_Q1_RD:
            begin
                // first walk only checks that the path is complete
                if (cnt_reg >= MAX_PATH)
                begin
                    one_cost_next = DIST_INF;
                    one_np_next   = 1'b1;
                    state_next    = ST_Q_ONE;
                end
                else
                begin
                    mem_raddr  = {cur_reg, d_reg};
                    state_next = ST_Q1_CHK;
                end
            end
            ST_Q1_CHK:
            begin
                if (rd_hop >= n_act)
                begin
                    one_cost_next = DIST_INF;
                    one_np_next   = 1'b1;
                    state_next    = ST_Q_ONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    cur_next = rd_hop[NODE_W-1:0];
                    if (rd_hop[NODE_W-1:0] == d_reg)
                    begin
                        cur_next   = s_reg;
                        state_next = ST_Q2_EMIT;
                    end
                    else
                    begin
                        state_next = ST_Q1_RD;
                    end
                end
            end
            ST_Q_ONE:
            begin
                if (slot_free)
                begin
                    emit_valid   = 1'b1;
                    emit.node    = s_reg;
                    emit.cost    = one_cost_reg;
                    emit.no_path = one_np_reg;
                    emit.last    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_Q2_EMIT:
            begin
                if (slot_free)
                begin
                    emit_valid   = 1'b1;
                    emit.node    = cur_reg;
                    emit.cost    = cost_reg;
                    emit.no_path = 1'b0;
                    emit.last    = (cur_reg == d_reg);
                    state_next   = (cur_reg == d_reg) ? ST_IDLE : ST_Q2_RD;
                end
            end
            ST_Q2_RD:
            begin
                mem_raddr  = {cur_reg, d_reg};
                state_next = ST_Q2_NXT;
            end
            ST_Q2_NXT:
            begin
                cur_next   = rd_hop[NODE_W-1:0];
                state_next = ST_Q2_EMIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid |-> slot_free)
        else $error("result emitted while output stage is full");

    a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid |-> (state_reg == ST_Q_ONE || state_reg == ST_Q2_EMIT))
        else $error("result emitted outside a query");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_IDLE ||
                    state_reg == ST_C_UPD))
        else $error("matrix write from unexpected state");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q1_RD) |-> (cnt_reg <= MAX_PATH))
        else $error("path walk overran its bound");
`endif

endmodule

@@ rtl/apsp_out.sv @@
module apsp_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        emit_valid,
    input  apsp_pkg::result_t           emit,
    output logic                        slot_free,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [apsp_pkg::NODE_W-1:0] path_node,
    output logic [apsp_pkg::DIST_W-1:0] path_cost,
    output logic                        no_path,
    output logic                        last
);

    import apsp_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg, res_next;

    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (emit_valid)
        begin
            valid_next = 1'b1;
            res_next   = emit;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign path_node = res_reg.node;
    assign path_cost = res_reg.cost;
    assign no_path   = res_reg.no_path;
    assign last      = res_reg.last;

endmodule

@@ rtl/all_pairs_shortest_path.sv @@
// All-pairs shortest paths (Floyd-Warshall) over up to 64 vertices, with a
// next-hop matrix for path readout. Distance and next hop of every pair share
// one 4096-entry memory with a registered read, and a single sequencer does
// all accesses. After reset, and for every clear item, the block sweeps the
// whole memory with in_ready low. A load item is written straight from idle.
// A compute item steps k and i over the n active vertices, reads the i,k leg
// and then, for each j, reads k,j, reads i,j and writes back where the sum
// is shorter; a row whose leg through k is infinite is skipped. A query first
// walks the path to check that it is complete, then walks it again to stream
// it; each streamed transfer repeats the total cost and the final one has
// last set. node_count may only be written while the block is idle.
module all_pairs_shortest_path (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [apsp_pkg::CNT_W-1:0]  node_count,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [apsp_pkg::NODE_W-1:0] source_node,
    input  logic [apsp_pkg::NODE_W-1:0] dest_node,
    input  logic [apsp_pkg::EDGE_W-1:0] edge_cost,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [apsp_pkg::NODE_W-1:0] path_node,
    output logic [apsp_pkg::DIST_W-1:0] path_cost,
    output logic                        no_path,
    output logic                        last
);

    import apsp_pkg::*;

    logic    slot_free;
    logic    emit_valid;
    result_t emit;

    apsp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .node_count  (node_count),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .source_node (source_node),
        .dest_node   (dest_node),
        .edge_cost   (edge_cost),
        .slot_free   (slot_free),
        .emit_valid  (emit_valid),
        .emit        (emit)
    );

    apsp_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit_valid (emit_valid),
        .emit       (emit),
        .slot_free  (slot_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .path_node  (path_node),
        .path_cost  (path_cost),
        .no_path    (no_path),
        .last       (last)
    );

endmodule

@@ tb/sv/all_pairs_shortest_path_checker.sv @@
module all_pairs_shortest_path_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [apsp_pkg::CNT_W-1:0]  node_count,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [apsp_pkg::NODE_W-1:0] source_node,
    input  logic [apsp_pkg::NODE_W-1:0] dest_node,
    input  logic [apsp_pkg::EDGE_W-1:0] edge_cost,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [apsp_pkg::NODE_W-1:0] path_node,
    input  logic [apsp_pkg::DIST_W-1:0] path_cost,
    input  logic                        no_path,
    input  logic                        last,
    output int                          errors,
    output int                          pending
);

    import apsp_pkg::*;

    logic [DIST_W-1:0] dist_tab [MAT_DEPTH];
    logic [HOP_W-1:0]  hop_tab  [MAT_DEPTH];
    logic [CNT_W-1:0]  active_cfg;
    result_t           expected_path [$];

    function automatic int used_nodes();
        return (active_cfg > NODES_CNT) ? NODES : int'(active_cfg);
    endfunction

    function automatic void queue_result(result_t r);
        expected_path = {expected_path, r};
    endfunction

    function automatic void clear_tables();
        for (int r = 0; r < NODE_SLOTS; r++)
            for (int c = 0; c < NODE_SLOTS; c++)
            begin
                dist_tab[r*NODE_SLOTS+c] = (r == c) ? '0 : DIST_INF;
                hop_tab[r*NODE_SLOTS+c]  = HOP_EMPTY;
            end
    endfunction

    function automatic void relax_tables();
        int n;
        logic [DIST_W-1:0] ik, kj;
        logic [DIST_W:0]   sum;
        n = used_nodes();
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
            begin
                ik = dist_tab[i*NODE_SLOTS+k];
                if (ik == DIST_INF)
                    continue;
                for (int j = 0; j < n; j++)
                begin
                    kj = dist_tab[k*NODE_SLOTS+j];
                    if (kj == DIST_INF)
                        continue;
                    sum = {1'b0, ik} + {1'b0, kj};
                    if (sum > {1'b0, DIST_MAX})
                        sum = {1'b0, DIST_MAX};
                    if (dist_tab[i*NODE_SLOTS+j] > sum[DIST_W-1:0])
                    begin
                        dist_tab[i*NODE_SLOTS+j] = sum[DIST_W-1:0];
                        hop_tab[i*NODE_SLOTS+j]  = hop_tab[i*NODE_SLOTS+k];
                    end
                end
            end
    endfunction

    function automatic void predict_path(int s, int d);
        int n, cnt, cur, hop;
        int walk [MAX_PATH];
        result_t r;
        n = used_nodes();
        cnt = 0;
        r.node = NODE_W'(s);
        r.cost = DIST_INF;
        r.no_path = 1'b1;
        r.last = 1'b1;
        if (s >= n || d >= n)
        begin
            queue_result(r);
            return;
        end
        if (s == d)
        begin
            r.cost = '0;
            r.no_path = 1'b0;
            queue_result(r);
            return;
        end
        walk[cnt++] = s;
        cur = s;
        while (cur != d)
        begin
            hop = int'(hop_tab[cur*NODE_SLOTS+d]);
            if (cnt >= MAX_PATH || hop >= n)
            begin
                queue_result(r);
                return;
            end
            walk[cnt++] = hop;
            cur = hop;
        end
        for (int i = 0; i < cnt; i++)
        begin
            r.node = NODE_W'(walk[i]);
            r.cost = dist_tab[s*NODE_SLOTS+d];
            r.no_path = 1'b0;
            r.last = (i == cnt - 1);
            queue_result(r);
        end
    endfunction

    assign pending = expected_path.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            errors = 0;
            active_cfg = NODE_COUNT_RESET;
            clear_tables();
            expected_path.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                active_cfg = node_count;
            if (out_valid && out_ready)
            begin
                if (expected_path.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result node %0d cost %0d", path_node, path_cost);
                    errors++;
                end
                else
                begin
                    want = expected_path.pop_front();
                    if (want.node !== path_node || want.cost !== path_cost
                        || want.no_path !== no_path || want.last !== last)
                    begin
                        if (errors < 10)
                            $display({"mismatch: exp node %0d cost %0d none %0b last %0b,",
                                      " got %0d %0d %0b %0b"},
                                     want.node, want.cost, want.no_path, want.last,
                                     path_node, path_cost, no_path, last);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                case (op_t'(operation))
                    OP_CLEAR: clear_tables();
                    OP_LOAD:
                        if (source_node != dest_node)
                        begin
                            dist_tab[source_node*NODE_SLOTS+dest_node] =
                                DIST_W'(edge_cost & COST_MASK);
                            hop_tab[source_node*NODE_SLOTS+dest_node] = {1'b0, dest_node};
                        end
                    OP_COMPUTE: relax_tables();
                    default: predict_path(int'(source_node), int'(dest_node));
                endcase
            end
        end
    end

endmodule

@@ tb/sv/all_pairs_shortest_path_tb.sv @@
module all_pairs_shortest_path_tb;
    import apsp_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  node_count;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        operation;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] dest_node;
    logic [EDGE_W-1:0] edge_cost;
    logic              out_valid;
    logic              out_ready;
    logic [NODE_W-1:0] path_node;
    logic [DIST_W-1:0] path_cost;
    logic              no_path;
    logic              last;
    int                errors;
    int                pending;
    int                cycles;
    bit                no_idle;
    bit                hold_req;
    bit                hold_ack;
    int                span;

    all_pairs_shortest_path u_top (.*);

    all_pairs_shortest_path_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[all_pairs_shortest_path] ERROR");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int g;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req != hold_ack)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_ack = hold_req;
            end
            g = no_idle ? 0 : $urandom_range(0, 16);
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send(op_t op, int s, int d, int c);
        int g;
        g = no_idle ? 0 : $urandom_range(0, 16);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        source_node <= NODE_W'(s);
        dest_node   <= NODE_W'(d);
        edge_cost   <= EDGE_W'(c);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // a query transfer drains behind any compute, so its last result marks idle
    task automatic settle();
        send(OP_QUERY, 0, 0, 0);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_count(int v);
        settle();
        cfg_valid  <= 1'b1;
        node_count <= CNT_W'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_node(int n);
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
    endfunction

    function automatic int pick_cost();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
    endfunction

    initial
    begin
        int n, loads, asks;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        node_count = NODE_COUNT_RESET;
        in_valid = 1'b0;
        operation = OP_CLEAR;
        source_node = '0;
        dest_node = '0;
        edge_cost = '0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        hold_ack = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed, full node count with a sparse graph
        send(OP_QUERY, 0, 0, 0);
        send(OP_QUERY, 0, 63, 0);
        send(OP_LOAD, 0, 1, 65535);
        send(OP_LOAD, 1, 2, 0);
        send(OP_LOAD, 5, 5, 7);
        send(OP_LOAD, 63, 0, 1);
        send(OP_LOAD, 2, 63, 65535);
        send(OP_LOAD, 0, 1, 3);
        send(OP_COMPUTE, 0, 0, 0);
        send(OP_QUERY, 0, 63, 0);
        send(OP_QUERY, 63, 2, 0);
        send(OP_QUERY, 5, 5, 0);
        send(OP_QUERY, 1, 0, 0);
        send(OP_QUERY, 42, 21, 0);
        write_count(1);
        send(OP_QUERY, 0, 0, 0);
        send(OP_QUERY, 0, 1, 0);
        send(OP_COMPUTE, 0, 0, 0);
        send(OP_CLEAR, 0, 0, 0);
        send(OP_QUERY, 63, 0, 0);

        for (int ph = 0; ph < 5; ph++)
        begin
            n = (ph == 3) ? 16 : $urandom_range(2, 8);
            write_count(n);
            no_idle = (ph == 1);
            send(OP_CLEAR, 0, 0, 0);
            span = 0;
            while (span < 28)
            begin
                loads = $urandom_range(4, 14);
                for (int i = 0; i < loads; i++)
                    send(OP_LOAD, pick_node(n), pick_node(n), pick_cost());
                if ($urandom_range(0, 5) != 0)
                    send(OP_COMPUTE, 0, 0, 0);
                else
                    send(op_t'($urandom_range(1, 3)), $urandom, $urandom, $urandom);
                if (ph == 2 && span == 0)
                    hold_req = ~hold_req;
                asks = $urandom_range(3, 8);
                for (int i = 0; i < asks; i++)
                    send(OP_QUERY, pick_node(n), pick_node(n), 0);
                span += loads + asks + 1;
            end
            if (ph == 4)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
                send(OP_QUERY, 0, n - 1, 0);
            end
        end
        write_count(64);
        send(OP_QUERY, 0, 63, 0);
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[all_pairs_shortest_path] OK");
        else
            $display("[all_pairs_shortest_path] ERROR");
        $finish;
    end

endmodule

@@ all_pairs_shortest_path.f @@
rtl/apsp_pkg.sv
rtl/apsp_ram.sv
rtl/apsp_ctrl.sv
rtl/apsp_out.sv
rtl/all_pairs_shortest_path.sv
tb/sv/all_pairs_shortest_path_checker.sv
tb/sv/all_pairs_shortest_path_tb.sv
